// ===== rtl/big_pkg.sv =====
// ----------------------------------------------------------------------------
// big_pkg
// Shared constants for the broadcast index generator.
// ----------------------------------------------------------------------------
`default_nettype none

package big_pkg;

   localparam int REG_DIMS            = 4;   // dimensions held in registers
   localparam int SIZE_WIDTH          = 16;  // width of one dimension size
   localparam int NUM_REGS            = 2 * REG_DIMS;
   localparam int CSR_ADDR_WIDTH      = 5;   // byte address of eight 32-bit registers
   localparam int OUT_INDEX_WIDTH     = 32;
   localparam int REQ_DATA_WIDTH      = 32;
   localparam int RSP_DATA_WIDTH      = 72;  // 66 bits of fields padded to bytes
   localparam int DIV_BITS_PER_STAGE  = 4;   // quotient bits resolved per stage
   localparam int MAX_DIMS_DEFAULT    = 4;
   localparam int INDEX_WIDTH_DEFAULT = 32;

endpackage : big_pkg

`default_nettype wire

// ===== rtl/broadcast_index_generator.sv =====
// ----------------------------------------------------------------------------
// broadcast_index_generator
// Maps result linear indexes to operand indexes under implicit expansion.
// ----------------------------------------------------------------------------
// Takes one result index per cycle when not stalled and returns, in order,
// the column-major indexes of the matching elements in operands A and B,
// plus a shape mismatch flag and an out-of-range flag. The index is split
// into coordinates by a pipelined restoring divider, four quotient bits per
// stage, one run of stages per dimension; then one multiply stage and one
// sum/compare stage. Throughput is one transfer per cycle while the
// response side accepts. Each stage holds its item only while the stage
// behind it is full, so bubbles close up under backpressure. Strides and
// the element count are registered from the size registers and follow a
// register write through a chain of multiply registers.
// ----------------------------------------------------------------------------
`default_nettype none

module broadcast_index_generator #(
   parameter int MAX_DIMS    = big_pkg::MAX_DIMS_DEFAULT,
   parameter int INDEX_WIDTH = big_pkg::INDEX_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request: [31:0] result_index
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [big_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // response: [31:0] a_index, [63:32] b_index, [64] shape_mismatch,
   //           [65] out_of_range, [71:66] zero
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [big_pkg::RSP_DATA_WIDTH-1:0]        rsp_tdata,
   // register port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [big_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic [31:0]                               csr_prdata,
   output logic                                      csr_pready
);
   import big_pkg::*;

   localparam int KW  = (INDEX_WIDTH < 32) ? INDEX_WIDTH : 32;
   localparam int BPS = DIV_BITS_PER_STAGE;
   localparam int SPD = (KW + BPS - 1) / BPS;   // divider stages per dimension
   localparam int NST = REG_DIMS * SPD;

   typedef struct packed {
      logic [KW-1:0]                          k;
      logic [KW-1:0]                          q;
      logic [SIZE_WIDTH-1:0]                  rem;
      logic [REG_DIMS-1:0][SIZE_WIDTH-1:0]    coord;
   } div_type;

   typedef struct packed {
      logic [KW-1:0]                              k;
      logic [REG_DIMS-1:0][OUT_INDEX_WIDTH-1:0]   pa;
      logic [REG_DIMS-1:0][OUT_INDEX_WIDTH-1:0]   pb;
   } mul_type;

   // ---------------------------------------------------------------- registers
   logic [NUM_REGS-1:0][SIZE_WIDTH-1:0] cfg_ff;
   logic [$clog2(NUM_REGS)-1:0]         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2 +: $clog2(NUM_REGS)];
   assign csr_prdata = {{(32-SIZE_WIDTH){1'b0}}, cfg_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= SIZE_WIDTH'(1);
         end
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         cfg_ff[csr_idx] <= csr_pwdata[SIZE_WIDTH-1:0];
      end
   end

   // ------------------------------------------------------------ shape logic
   logic [REG_DIMS-1:0][SIZE_WIDTH-1:0] da_w, db_w, rsz_w, sz_w;
   logic [REG_DIMS-1:0]                 dim_bad_w;
   logic                                mism_w;

   always_comb begin
      for (int i = 0; i < REG_DIMS; i++) begin
         if (i < MAX_DIMS) begin
            da_w[i] = cfg_ff[i];
            db_w[i] = cfg_ff[REG_DIMS + i];
         end else begin
            da_w[i] = SIZE_WIDTH'(1);
            db_w[i] = SIZE_WIDTH'(1);
         end
         dim_bad_w[i] = 1'b0;
         if (da_w[i] == db_w[i])              rsz_w[i] = da_w[i];
         else if (da_w[i] == SIZE_WIDTH'(1))  rsz_w[i] = db_w[i];
         else if (db_w[i] == SIZE_WIDTH'(1))  rsz_w[i] = da_w[i];
         else begin
            rsz_w[i]     = SIZE_WIDTH'(1);
            dim_bad_w[i] = 1'b1;
         end
         // zero-size dimension divides by one; the range check rejects it anyway
         sz_w[i] = (rsz_w[i] == '0) ? SIZE_WIDTH'(1) : rsz_w[i];
      end
      mism_w = |dim_bad_w;
   end

   // element count and strides, a multiply per register
   logic [2*SIZE_WIDTH-1:0]  cnt1_ff;
   logic [3*SIZE_WIDTH-1:0]  cnt2_ff;
   logic [4*SIZE_WIDTH-1:0]  count_ff;
   logic [REG_DIMS-1:0][OUT_INDEX_WIDTH-1:0] sa_ff, sb_ff;
   logic [REG_DIMS-1:0][OUT_INDEX_WIDTH-1:0] sa_in, sb_in;
   logic [REG_DIMS-1:0][SIZE_WIDTH-1:0]      fa_w, fb_w;

   always_comb begin
      for (int i = 0; i < REG_DIMS; i++) begin
         fa_w[i] = (da_w[i] == '0) ? SIZE_WIDTH'(1) : da_w[i];
         fb_w[i] = (db_w[i] == '0) ? SIZE_WIDTH'(1) : db_w[i];
      end
      sa_in[0] = OUT_INDEX_WIDTH'(1);
      sb_in[0] = OUT_INDEX_WIDTH'(1);
      for (int i = 1; i < REG_DIMS; i++) begin
         sa_in[i] = OUT_INDEX_WIDTH'(sa_ff[i-1] * fa_w[i-1]);
         sb_in[i] = OUT_INDEX_WIDTH'(sb_ff[i-1] * fb_w[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      cnt1_ff  <= rsz_w[0] * rsz_w[1];
      cnt2_ff  <= cnt1_ff * rsz_w[2];
      count_ff <= cnt2_ff * rsz_w[3];
      sa_ff    <= sa_in;
      sb_ff    <= sb_in;
   end

   // -------------------------------------------------------- pipeline control
   localparam int NV = NST + 2;   // divider stages, multiply stage, output stage
   logic [NV-1:0] vld_ff;
   logic [NV-1:0] ld;

   always_comb begin
      ld[NV-1] = !vld_ff[NV-1] || rsp_tready;
      for (int s = NV - 2; s >= 0; s--) begin
         ld[s] = !vld_ff[s] || ld[s+1];
      end
   end

   assign req_tready = ld[0];
   assign rsp_tvalid = vld_ff[NV-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NV; s++) begin
            if (ld[s]) begin
               vld_ff[s] <= (s == 0) ? req_tvalid : vld_ff[(s == 0) ? 0 : s - 1];
            end
         end
      end
   end

   // ----------------------------------------------------------- divider stages
   div_type div_ff  [NST];
   div_type div_src [NST];
   div_type div_in  [NST];
   div_type req_pkt;

   always_comb begin
      req_pkt       = '0;
      req_pkt.k     = req_tdata[KW-1:0];
      req_pkt.q     = req_tdata[KW-1:0];
      div_src[0]    = req_pkt;
      for (int s = 1; s < NST; s++) begin
         div_src[s] = div_ff[s-1];
      end
   end

   for (genvar gs = 0; gs < NST; gs++) begin : g_div
      localparam int D = gs / SPD;
      localparam int P = gs % SPD;

      always_comb begin
         div_type             nxt;
         logic [SIZE_WIDTH:0] r;
         int                  pos;
         nxt = div_src[gs];
         r   = '0;
         pos = 0;
         if (P == 0) nxt.rem = '0;       // new dimension: divide the quotient so far
         for (int j = 0; j < BPS; j++) begin
            pos = P * BPS + j;
            if (pos < KW) begin
               r = {nxt.rem, nxt.q[KW-1-pos]};
               if (r >= {1'b0, sz_w[D]}) begin
                  r                = r - {1'b0, sz_w[D]};
                  nxt.q[KW-1-pos] = 1'b1;
               end else begin
                  nxt.q[KW-1-pos] = 1'b0;
               end
               nxt.rem = r[SIZE_WIDTH-1:0];
            end
         end
         if (P == SPD - 1) nxt.coord[D] = nxt.rem;
         div_in[gs] = nxt;
      end

      always_ff @(posedge clock) begin
         if (ld[gs]) div_ff[gs] <= div_in[gs];
      end
   end

   // ---------------------------------------------------------- multiply stage
   mul_type mul_ff, mul_in;

   always_comb begin
      mul_in.k = div_ff[NST-1].k;
      for (int i = 0; i < REG_DIMS; i++) begin
         mul_in.pa[i] = (da_w[i] != SIZE_WIDTH'(1))
                      ? OUT_INDEX_WIDTH'(div_ff[NST-1].coord[i] * sa_ff[i]) : '0;
         mul_in.pb[i] = (db_w[i] != SIZE_WIDTH'(1))
                      ? OUT_INDEX_WIDTH'(div_ff[NST-1].coord[i] * sb_ff[i]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[NST]) mul_ff <= mul_in;
   end

   // ------------------------------------------------------------ output stage
   logic [RSP_DATA_WIDTH-1:0]  rsp_ff, rsp_in;
   logic [OUT_INDEX_WIDTH-1:0] ia_w, ib_w;

   always_comb begin
      ia_w = '0;
      ib_w = '0;
      for (int i = 0; i < REG_DIMS; i++) begin
         ia_w = ia_w + mul_ff.pa[i];
         ib_w = ib_w + mul_ff.pb[i];
      end
      rsp_in = '0;
      if (mism_w) begin
         rsp_in[64] = 1'b1;
      end else if ({{(4*SIZE_WIDTH-KW){1'b0}}, mul_ff.k} >= count_ff) begin
         rsp_in[65] = 1'b1;
      end else begin
         rsp_in[31:0]  = ia_w;
         rsp_in[63:32] = ib_w;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[NV-1]) rsp_ff <= rsp_in;
   end

   assign rsp_tdata = rsp_ff;

endmodule : broadcast_index_generator

`default_nettype wire
